// File: rtl/ace_pkg.sv
`default_nettype none

package ace_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 5;

  localparam logic [DATA_W-1:0] MSB_MASK = 32'h8000_0000;

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_NOP     = 5'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 5'd1;
  localparam logic [CMD_W-1:0] CMD_SUB     = 5'd2;
  localparam logic [CMD_W-1:0] CMD_OR      = 5'd3;
  localparam logic [CMD_W-1:0] CMD_AND     = 5'd4;
  localparam logic [CMD_W-1:0] CMD_XOR     = 5'd5;
  localparam logic [CMD_W-1:0] CMD_NOT     = 5'd6;
  localparam logic [CMD_W-1:0] CMD_FLIP    = 5'd7;
  localparam logic [CMD_W-1:0] CMD_SHL     = 5'd8;
  localparam logic [CMD_W-1:0] CMD_SHR     = 5'd9;
  localparam logic [CMD_W-1:0] CMD_GET     = 5'd10;
  localparam logic [CMD_W-1:0] CMD_PUT     = 5'd11;
  localparam logic [CMD_W-1:0] CMD_INC     = 5'd12;
  localparam logic [CMD_W-1:0] CMD_DEC     = 5'd13;
  localparam logic [CMD_W-1:0] CMD_IMM     = 5'd14;
  localparam logic [CMD_W-1:0] CMD_NEG     = 5'd15;
  localparam logic [CMD_W-1:0] CMD_B2A     = 5'd16;
  localparam logic [CMD_W-1:0] CMD_B2R     = 5'd17;
  localparam logic [CMD_W-1:0] CMD_B2T     = 5'd18;
  localparam logic [CMD_W-1:0] CMD_B2V     = 5'd19;
  localparam logic [CMD_W-1:0] CMD_SWAP    = 5'd20;
  localparam logic [CMD_W-1:0] CMD_A2B     = 5'd21;
  localparam logic [CMD_W-1:0] CMD_A2T     = 5'd22;
  localparam logic [CMD_W-1:0] CMD_A2R     = 5'd23;
  localparam logic [CMD_W-1:0] CMD_A2V     = 5'd24;
  localparam logic [CMD_W-1:0] CMD_T2A     = 5'd25;
  localparam logic [CMD_W-1:0] CMD_R2A     = 5'd26;
  localparam logic [CMD_W-1:0] CMD_V2A     = 5'd27;
  localparam logic [CMD_W-1:0] CMD_MEMSIZE = 5'd28;
  localparam logic [CMD_W-1:0] CMD_REPEAT  = 5'd29;

  // Architectural registers of the machine.
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] r;
  } regs_t;

  // One result word.
  typedef struct packed {
    logic [DATA_W-1:0] acc_value;
    logic [DATA_W-1:0] operand_value;
    logic              acc_zero;
    logic              acc_equals_operand;
    logic              acc_msb_only;
    logic              acc_negative;
    logic              acc_has_ones_of_operand;
    logic              acc_has_zeros_of_operand;
    logic              repeat_again;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/ace_ram.sv
`default_nettype none

module ace_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read returns the old contents when the same word is written in that cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/ace_alu.sv
`default_nettype none

module ace_alu
  import ace_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  wire logic [CMD_W-1:0]  cmd,
  input  wire logic [DATA_W-1:0] imm,
  input  wire regs_t             cur,
  input  wire logic [DATA_W-1:0] mem_word,
  output regs_t                  nxt,
  output result_t                res
);

  logic again;

  always_comb begin
    nxt   = cur;
    again = 1'b0;
    unique case (cmd)
      CMD_ADD:     nxt.a = cur.a + cur.b;
      CMD_SUB:     nxt.a = cur.a - cur.b;
      CMD_OR:      nxt.a = cur.a | cur.b;
      CMD_AND:     nxt.a = cur.a & cur.b;
      CMD_XOR:     nxt.a = cur.a ^ cur.b;
      CMD_NOT:     nxt.a = ~cur.a;
      CMD_FLIP:    nxt.a = cur.a ^ MSB_MASK;
      CMD_SHL:     nxt.a = cur.a << cur.b[4:0];
      CMD_SHR:     nxt.a = cur.a >> cur.b[4:0];
      CMD_GET:     nxt.a = mem_word;
      CMD_INC:     nxt.a = cur.a + 32'd1;
      CMD_DEC:     nxt.a = cur.a - 32'd1;
      CMD_IMM:     nxt.b = imm;
      CMD_NEG:     nxt.b = ~cur.b + 32'd1;
      CMD_B2A:     nxt.a = cur.b;
      CMD_B2R:     nxt.r = cur.b;
      CMD_B2T:     nxt.t = cur.b;
      CMD_B2V:     nxt.v = cur.b;
      CMD_SWAP: begin
        nxt.a = cur.v;
        nxt.v = cur.a;
      end
      CMD_A2B:     nxt.b = cur.a;
      CMD_A2T:     nxt.t = cur.a;
      CMD_A2R:     nxt.r = cur.a;
      CMD_A2V:     nxt.v = cur.a;
      CMD_T2A:     nxt.a = cur.t;
      CMD_R2A:     nxt.a = cur.r;
      CMD_V2A:     nxt.a = cur.v;
      CMD_MEMSIZE: nxt.a = DATA_W'(MEM_WORDS);
      CMD_REPEAT: begin
        nxt.r = cur.r - 32'd1;
        again = (cur.r != 32'd1);
      end
      default:     nxt = cur;
    endcase
  end

  always_comb begin
    res.acc_value                = nxt.a;
    res.operand_value            = nxt.b;
    res.acc_zero                 = (nxt.a == '0);
    res.acc_equals_operand       = (nxt.a == nxt.b);
    res.acc_msb_only             = (nxt.a == MSB_MASK);
    res.acc_negative             = nxt.a[DATA_W-1];
    res.acc_has_ones_of_operand  = ((nxt.a & nxt.b) == nxt.b);
    res.acc_has_zeros_of_operand = ((nxt.a | nxt.b) == nxt.b);
    res.repeat_again             = again;
  end

endmodule

`default_nettype wire

// File: rtl/accumulator_core_execute.sv
// Channel   Direction  Handshake          Word
// in_       input      in_valid/in_stall   in_command, in_immediate
// out_      output     out_valid/out_stall A, B and seven condition flags
//
// Each accepted word executes in the cycle it is accepted, and its result
// is registered for the out_ ports; one word per cycle is sustained while
// out_stall is low. The data memory read for a get is issued from the next
// value of A, so a get needs no separate read. After reset the block clears
// the data memory, one word per cycle, and holds in_stall high until the
// last address has been written. A stalled result is held on the out_ ports
// while one more word is taken into a skid register behind it.
`default_nettype none

module accumulator_core_execute
  import ace_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [DATA_W-1:0] in_immediate,

  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [DATA_W-1:0] out_acc_value,
  output logic      [DATA_W-1:0] out_operand_value,
  output logic                   out_acc_zero,
  output logic                   out_acc_equals_operand,
  output logic                   out_acc_msb_only,
  output logic                   out_acc_negative,
  output logic                   out_acc_has_ones_of_operand,
  output logic                   out_acc_has_zeros_of_operand,
  output logic                   out_repeat_again
);

  localparam int unsigned ADDR_W = $clog2(MEM_WORDS);

  // Architectural registers A, B, T, V and R.
  regs_t state_r;
  regs_t state_nxt;
  regs_t alu_nxt;
  result_t alu_res;

  // Clearing pass over the data memory after reset.
  logic              clearing_r;
  logic              clearing_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_addr_nxt;

  // Memory ports and the read-during-write bypass.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic [DATA_W-1:0] mem_word;
  logic              fwd_hit_r;
  logic [DATA_W-1:0] fwd_data_r;

  // Output register and skid register.
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;
  result_t out_res_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;
  result_t skid_res_r;
  result_t skid_res_nxt;

  logic accept;
  logic out_free;

  // The skid register is only filled when the output is stalled, so any
  // word taken while it is empty always has a place to go.
  assign in_stall = clearing_r | skid_valid_r;
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  // The memory word for a get is the one read last cycle at the current A.
  // If that same word was written in that cycle, the written data wins.
  assign mem_word = fwd_hit_r ? fwd_data_r : mem_rdata;

  ace_alu #(
    .MEM_WORDS (MEM_WORDS)
  ) u_alu (
    .cmd      (in_command),
    .imm      (in_immediate),
    .cur      (state_r),
    .mem_word (mem_word),
    .nxt      (alu_nxt),
    .res      (alu_res)
  );

  assign state_nxt = accept ? alu_nxt : state_r;

  // The read address always follows the value A will hold next cycle, so
  // the memory output tracks mem[A] without a separate read.
  assign mem_raddr = state_nxt.a[ADDR_W-1:0];

  always_comb begin
    if (clearing_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = accept && (in_command == CMD_PUT);
      mem_waddr = state_r.a[ADDR_W-1:0];
      mem_wdata = state_r.v;
    end
  end

  ace_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // The pass ends after the last address has been written.
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = alu_res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      clearing_r   <= 1'b1;
      clr_addr_r   <= '0;
      fwd_hit_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clearing_r   <= clearing_nxt;
      clr_addr_r   <= clr_addr_nxt;
      fwd_hit_r    <= mem_we && (mem_waddr == mem_raddr);
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= mem_wdata;
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid                    = out_valid_r;
  assign out_acc_value                = out_res_r.acc_value;
  assign out_operand_value            = out_res_r.operand_value;
  assign out_acc_zero                 = out_res_r.acc_zero;
  assign out_acc_equals_operand       = out_res_r.acc_equals_operand;
  assign out_acc_msb_only             = out_res_r.acc_msb_only;
  assign out_acc_negative             = out_res_r.acc_negative;
  assign out_acc_has_ones_of_operand  = out_res_r.acc_has_ones_of_operand;
  assign out_acc_has_zeros_of_operand = out_res_r.acc_has_zeros_of_operand;
  assign out_repeat_again             = out_res_r.repeat_again;

endmodule

`default_nettype wire

// File: rtl/ace_checker.sv
`default_nettype none

module ace_checker
  import ace_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [CMD_W-1:0]  in_command,
  input wire logic [DATA_W-1:0] in_immediate,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [DATA_W-1:0] out_acc_value,
  input wire logic [DATA_W-1:0] out_operand_value,
  input wire logic              out_acc_zero,
  input wire logic              out_acc_equals_operand,
  input wire logic              out_acc_msb_only,
  input wire logic              out_acc_negative,
  input wire logic              out_acc_has_ones_of_operand,
  input wire logic              out_acc_has_zeros_of_operand,
  input wire logic              out_repeat_again
);

  logic take_direct;

  // A word taken while the output is free shows up on the next cycle.
  assign take_direct = in_valid && !in_stall && (!out_valid || !out_stall);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_acc_value)
      && $stable(out_operand_value) && $stable(out_repeat_again))
    else $error("stalled result word changed");

  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    take_direct |=> out_valid)
    else $error("accepted word did not reach the output");

  a_imm_operand: assert property (@(posedge clk) disable iff (!rst_n)
    take_direct && (in_command == CMD_IMM) |=>
      out_operand_value == $past(in_immediate))
    else $error("immediate not loaded into B");

  a_repeat_only: assert property (@(posedge clk) disable iff (!rst_n)
    take_direct && (in_command != CMD_REPEAT) |=> !out_repeat_again)
    else $error("repeat flag set by another command");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_acc_zero == (out_acc_value == '0))
      && (out_acc_negative == out_acc_value[DATA_W-1])
      && (out_acc_equals_operand == (out_acc_value == out_operand_value))
      && (out_acc_msb_only == (out_acc_value == MSB_MASK))
      && (out_acc_has_ones_of_operand
          == ((out_acc_value & out_operand_value) == out_operand_value))
      && (out_acc_has_zeros_of_operand
          == ((out_acc_value | out_operand_value) == out_operand_value)))
    else $error("condition flags disagree with A and B");

endmodule

bind accumulator_core_execute ace_checker u_ace_checker (.*);

`default_nettype wire
